/* rtl/sadwta_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sadwta_pkg
// shared types and constants of the sad stereo matcher
// ----------------------------------------------------------------------------
package sadwta_pkg;

    localparam logic [7:0] DISP_CAP = 8'd254;

    // register indexes on the config port
    localparam logic [2:0] REG_RADIUS = 3'd0;
    localparam logic [2:0] REG_MAXD   = 3'd1;
    localparam logic [2:0] REG_SCALE  = 3'd2;
    localparam logic [2:0] REG_WIDTH  = 3'd3;
    localparam logic [2:0] REG_HEIGHT = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_ROW,
        ST_STREAM,
        ST_DRAIN,
        ST_SCAN,
        ST_SCALE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear_chain;
        logic clear_sums;
        logic acc_en;
    } cell_ctl_t;

endpackage

/* rtl/stereo_sad_disparity_wta_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_sad_disparity_wta_core
// sad block matching stereo with winner-take-all over all disparities
// ----------------------------------------------------------------------------
// channel  | dir | word
// s_*      | in  | left and right gray pixel, raster order
// m_*      | out | row, column, left and right disparity, tlast on frame end
// apb      | in  | window radius, max disparity, scale, width, height
//
// each result streams every window row through the cell row (one line
// store read per cycle), then scans the disparities and scales the winners;
// an input that triggers no result leaves the core idle.
// rst_n clears counters and control; line store contents are not cleared.
// m_tready low stalls only the final hand-off; the next word may be accepted
// while a result waits.
// ----------------------------------------------------------------------------
module stereo_sad_disparity_wta_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_RADIUS = 7,
    parameter int MAX_DISP   = 47
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // left_pixel[7:0], right_pixel[15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_row, out_col, left disp, right disp, zero pad
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sadwta_pkg::*;

    localparam int LINES = 2 * MAX_RADIUS + 1;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SLW   = $clog2(LINES);
    localparam int RW    = $clog2(MAX_RADIUS + 1);
    localparam int NC    = MAX_DISP + 1;
    localparam int DW    = $clog2(MAX_DISP + 1);
    localparam int PW    = $clog2(MAX_WIDTH + MAX_RADIUS + 2 * MAX_DISP + 2) + 2;
    localparam int SW    = $clog2(255 * LINES * LINES + 1);
    localparam int DEPTH = LINES * (2 ** CW);

    // config registers
    logic [2:0]  radius_reg;
    logic [5:0]  maxd_reg;
    logic [7:0]  scale_reg;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic        cfg_wr;

    logic [RW-1:0] r_eff;
    logic [DW-1:0] dm_eff;
    logic [CW:0]   w_eff, h_eff;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= 3'd2;
            maxd_reg   <= 6'd15;
            scale_reg  <= 8'd15;
            width_reg  <= 11'd640;
            height_reg <= 11'd480;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_RADIUS: radius_reg <= pwdata[2:0];
                REG_MAXD:   maxd_reg   <= pwdata[5:0];
                REG_SCALE:  scale_reg  <= pwdata[7:0];
                REG_WIDTH:  width_reg  <= pwdata[10:0];
                REG_HEIGHT: height_reg <= pwdata[10:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_RADIUS: prdata = {29'd0, radius_reg};
            REG_MAXD:   prdata = {26'd0, maxd_reg};
            REG_SCALE:  prdata = {24'd0, scale_reg};
            REG_WIDTH:  prdata = {21'd0, width_reg};
            REG_HEIGHT: prdata = {21'd0, height_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign r_eff  = (int'(radius_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_reg);
    assign dm_eff = (int'(maxd_reg) > MAX_DISP) ? DW'(MAX_DISP) : DW'(maxd_reg);
    assign w_eff  = (width_reg == 11'd0) ? (CW+1)'(1) :
                    (int'(width_reg) > MAX_WIDTH) ? (CW+1)'(MAX_WIDTH) : (CW+1)'(width_reg);
    assign h_eff  = (height_reg == 11'd0) ? (CW+1)'(1) :
                    (int'(height_reg) > MAX_WIDTH) ? (CW+1)'(MAX_WIDTH) : (CW+1)'(height_reg);

    // signed views for planning
    logic signed [PW-1:0] sr, sdm, sw, sh, sc, srw, span_s, last_s, jz, jst, jen;
    logic                 cond, single, row_end, any;

    // counters
    logic [CW-1:0]  col_reg, row_reg;
    logic [SLW-1:0] slot_reg;
    logic           acc;

    assign sr     = $signed(PW'(r_eff));
    assign sdm    = $signed(PW'(dm_eff));
    assign sw     = $signed(PW'(w_eff));
    assign sh     = $signed(PW'(h_eff));
    assign sc     = $signed(PW'(col_reg));
    assign srw    = $signed(PW'(row_reg));
    assign span_s = PW'(2 * sr + 1);
    assign last_s = PW'(sw - 1 - sr);
    assign jz     = sc - sr - sdm;

    always_comb
    begin
        cond    = (sw >= span_s) && (sh >= span_s) && (srw >= 2 * sr) && (srw <= sh - 1);
        single  = (jz >= sr) && (jz <= last_s);
        row_end = (sc >= sw - 1);
        if (row_end)
        begin
            jst = (jz >= sr) ? jz : sr;
            jen = last_s;
            any = cond && (jst <= jen);
        end
        else
        begin
            jst = jz;
            jen = jz;
            any = cond && single;
        end
    end

    // fsm
    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign acc      = s_tvalid && s_tready;

    // job registers
    logic [CW-1:0]        jcur_reg, jend_reg, irow_reg, last_reg;
    logic                 fdrow_reg;
    logic [SLW-1:0]       top_reg, yslot_reg;
    logic [RW:0]          krow_reg;
    logic signed [PW-1:0] xi_reg, xe_reg, lo_reg, hi_reg, sj;
    logic [SLW-1:0]       top_slot;
    logic signed [PW-1:0] irow_s;

    assign irow_s   = srw - sr;
    assign top_slot = (int'(slot_reg) >= 2 * int'(r_eff)) ?
                      SLW'(int'(slot_reg) - 2 * int'(r_eff)) :
                      SLW'(int'(slot_reg) + LINES - 2 * int'(r_eff));
    assign sj       = $signed(PW'(jcur_reg));

    // pipeline from line store to cells
    logic [15:0]          mem [DEPTH];
    logic [15:0]          rdata_reg;
    logic                 s1v_reg, bv_reg;
    logic signed [PW-1:0] s1x_reg, bx_reg;
    logic [7:0]           bleft_reg;

    always_ff @(posedge clk)
    begin
        if (acc)
            mem[{slot_reg, col_reg}] <= s_tdata;
        rdata_reg <= mem[{yslot_reg, xi_reg[CW-1:0]}];
    end

    // winner scan
    logic [DW-1:0]      d_reg;
    logic [SW:0]        bestl_reg, bestr_reg, bound;
    logic [DW-1:0]      dl_reg, dr_reg;
    logic               fl_reg, fr_reg;
    logic [SW-1:0]      sel_l, sel_r;
    logic [2*RW+1:0]    sq;
    logic [RW:0]        span_u;
    logic [DW+7:0]      prodl_reg, prodr_reg;

    assign span_u = {r_eff, 1'b1};
    assign sq     = (2*RW+2)'(span_u) * (2*RW+2)'(span_u);
    assign bound  = (SW+1)'({sq, 8'd0}) - (SW+1)'(sq);

    cell_ctl_t ctl;
    assign ctl = '{clear_chain: (state_reg == ST_ROW),
                   clear_sums:  (state_reg == ST_CENTRE),
                   acc_en:      bv_reg};

    sadwta_chain #(.NC(NC), .PW(PW), .SW(SW), .DW(DW)) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .left_pix  (bleft_reg),
        .left_pos  (bx_reg),
        .lo        (lo_reg),
        .hi        (hi_reg),
        .wlim      (sw),
        .in_pix    (rdata_reg[15:8]),
        .in_pos    (s1x_reg),
        .in_vld    (s1v_reg),
        .sel       (d_reg),
        .sel_sum_l (sel_l),
        .sel_sum_r (sel_r)
    );

    // output register
    logic            outv_reg;
    logic [9:0]      orow_reg, ocol_reg;
    logic [7:0]      odl_reg, odr_reg;
    logic            olast_reg;
    logic            emit;
    logic [CW+9:0]   rowx, colx;
    logic [7:0]      capl, capr;

    assign emit = (state_reg == ST_EMIT) && (!outv_reg || m_tready);
    assign rowx = {10'd0, irow_reg};
    assign colx = {10'd0, jcur_reg};
    assign capl = (prodl_reg > (DW+8)'(DISP_CAP)) ? DISP_CAP : prodl_reg[7:0];
    assign capr = (prodr_reg > (DW+8)'(DISP_CAP)) ? DISP_CAP : prodr_reg[7:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (acc && any)
                    state_next = ST_CENTRE;
            ST_CENTRE:
                state_next = ST_ROW;
            ST_ROW:
                state_next = ST_STREAM;
            ST_STREAM:
                if (xi_reg == xe_reg)
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (!s1v_reg && !bv_reg)
                    state_next = (krow_reg == {r_eff, 1'b0}) ? ST_SCAN : ST_ROW;
            ST_SCAN:
                if (d_reg == dm_eff)
                    state_next = ST_SCALE;
            ST_SCALE:
                state_next = ST_EMIT;
            ST_EMIT:
                if (emit)
                    state_next = (jcur_reg == jend_reg) ? ST_IDLE : ST_CENTRE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            slot_reg  <= '0;
            s1v_reg   <= 1'b0;
            bv_reg    <= 1'b0;
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            s1v_reg   <= (state_reg == ST_STREAM);
            bv_reg    <= s1v_reg;
            if (acc)
            begin
                if (sc + 1 >= sw)
                begin
                    col_reg <= '0;
                    if (srw + 1 >= sh)
                    begin
                        row_reg  <= '0;
                        slot_reg <= '0;
                    end
                    else
                    begin
                        row_reg  <= row_reg + 1'b1;
                        slot_reg <= (int'(slot_reg) == LINES - 1) ? '0 : slot_reg + 1'b1;
                    end
                end
                else
                    col_reg <= col_reg + 1'b1;
            end
            if (emit)
                outv_reg <= 1'b1;
            else if (m_tready)
                outv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        s1x_reg   <= xi_reg;
        bx_reg    <= s1x_reg;
        bleft_reg <= rdata_reg[7:0];
        case (state_reg)
            ST_IDLE:
                if (acc)
                begin
                    jcur_reg  <= jst[CW-1:0];
                    jend_reg  <= jen[CW-1:0];
                    last_reg  <= last_s[CW-1:0];
                    irow_reg  <= irow_s[CW-1:0];
                    fdrow_reg <= (irow_s == sh - 1 - sr);
                    top_reg   <= top_slot;
                end
            ST_CENTRE:
            begin
                krow_reg  <= '0;
                yslot_reg <= top_reg;
                lo_reg    <= sj - sr;
                hi_reg    <= sj + sr;
            end
            ST_ROW:
            begin
                xi_reg <= sj - sr - sdm;
                xe_reg <= sj + sr + sdm;
            end
            ST_STREAM:
                if (xi_reg != xe_reg)
                    xi_reg <= PW'(xi_reg + 1);
            ST_DRAIN:
                if (!s1v_reg && !bv_reg)
                begin
                    krow_reg  <= krow_reg + 1'b1;
                    yslot_reg <= (int'(yslot_reg) == LINES - 1) ? '0 : yslot_reg + 1'b1;
                    d_reg     <= '0;
                    bestl_reg <= bound;
                    bestr_reg <= bound;
                    fl_reg    <= 1'b0;
                    fr_reg    <= 1'b0;
                    dl_reg    <= '0;
                    dr_reg    <= '0;
                end
            ST_SCAN:
            begin
                // strict compare keeps the lower disparity on ties
                if ((SW+1)'(sel_l) < bestl_reg)
                begin
                    bestl_reg <= (SW+1)'(sel_l);
                    dl_reg    <= d_reg;
                    fl_reg    <= 1'b1;
                end
                if ((SW+1)'(sel_r) < bestr_reg)
                begin
                    bestr_reg <= (SW+1)'(sel_r);
                    dr_reg    <= d_reg;
                    fr_reg    <= 1'b1;
                end
                if (d_reg != dm_eff)
                    d_reg <= d_reg + 1'b1;
            end
            ST_SCALE:
            begin
                prodl_reg <= (DW+8)'(dl_reg) * (DW+8)'(scale_reg);
                prodr_reg <= (DW+8)'(dr_reg) * (DW+8)'(scale_reg);
            end
            ST_EMIT:
                if (emit)
                begin
                    orow_reg  <= rowx[9:0];
                    ocol_reg  <= colx[9:0];
                    odl_reg   <= fl_reg ? capl : 8'd0;
                    odr_reg   <= fr_reg ? capr : 8'd0;
                    olast_reg <= fdrow_reg && (jcur_reg == last_reg);
                    if (jcur_reg != jend_reg)
                        jcur_reg <= jcur_reg + 1'b1;
                end
            default:
                ;
        endcase
    end

    assign m_tvalid = outv_reg;
    assign m_tdata  = {4'd0, odr_reg, odl_reg, ocol_reg, orow_reg};
    assign m_tlast  = olast_reg;

endmodule

/* rtl/sadwta_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sadwta_cell
// one disparity: holds a right pixel from the chain and both window sums
// ----------------------------------------------------------------------------
module sadwta_cell #(
    parameter int PW = 13,
    parameter int SW = 16,
    parameter int DW = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sadwta_pkg::cell_ctl_t ctl,
    input  logic [DW-1:0]         disp,
    input  logic [7:0]            left_pix,
    input  logic signed [PW-1:0]  left_pos,
    input  logic signed [PW-1:0]  lo,
    input  logic signed [PW-1:0]  hi,
    input  logic signed [PW-1:0]  wlim,
    input  logic [7:0]            in_pix,
    input  logic signed [PW-1:0]  in_pos,
    input  logic                  in_vld,
    output logic [7:0]            out_pix,
    output logic signed [PW-1:0]  out_pos,
    output logic                  out_vld,
    output logic [SW-1:0]         sum_l,
    output logic [SW-1:0]         sum_r
);
    import sadwta_pkg::*;

    logic [7:0]           pix_reg;
    logic signed [PW-1:0] pos_reg;
    logic                 vld_reg;
    logic [SW-1:0]        suml_reg, suml_next;
    logic [SW-1:0]        sumr_reg, sumr_next;
    logic [7:0]           diff;
    logic [7:0]           lterm, rterm;
    logic                 l_in, r_in;

    always_comb
    begin
        diff  = (left_pix > pix_reg) ? left_pix - pix_reg : pix_reg - left_pix;
        l_in  = (left_pos >= lo) && (left_pos <= hi);
        r_in  = (pos_reg >= lo) && (pos_reg <= hi);
        lterm = 8'd0;
        rterm = 8'd0;
        // positions outside the other image cost the disparity itself
        if (l_in)
            lterm = (pos_reg >= 0) ? diff : 8'(disp);
        if (r_in)
            rterm = (left_pos < wlim) ? diff : 8'(disp);
        suml_next = suml_reg + SW'(lterm);
        sumr_next = sumr_reg + SW'(rterm);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            suml_reg <= '0;
            sumr_reg <= '0;
        end
        else
        begin
            vld_reg <= ctl.clear_chain ? 1'b0 : in_vld;
            if (ctl.clear_sums)
            begin
                suml_reg <= '0;
                sumr_reg <= '0;
            end
            else if (ctl.acc_en && vld_reg)
            begin
                suml_reg <= suml_next;
                sumr_reg <= sumr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= in_pix;
        pos_reg <= in_pos;
    end

    assign out_pix = pix_reg;
    assign out_pos = pos_reg;
    assign out_vld = vld_reg;
    assign sum_l   = suml_reg;
    assign sum_r   = sumr_reg;

endmodule

/* rtl/sadwta_chain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sadwta_chain
// row of disparity cells with a select port for the winner scan
// ----------------------------------------------------------------------------
module sadwta_chain #(
    parameter int NC = 48,
    parameter int PW = 13,
    parameter int SW = 16,
    parameter int DW = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sadwta_pkg::cell_ctl_t ctl,
    input  logic [7:0]            left_pix,
    input  logic signed [PW-1:0]  left_pos,
    input  logic signed [PW-1:0]  lo,
    input  logic signed [PW-1:0]  hi,
    input  logic signed [PW-1:0]  wlim,
    input  logic [7:0]            in_pix,
    input  logic signed [PW-1:0]  in_pos,
    input  logic                  in_vld,
    input  logic [DW-1:0]         sel,
    output logic [SW-1:0]         sel_sum_l,
    output logic [SW-1:0]         sel_sum_r
);
    import sadwta_pkg::*;

    logic [7:0]           lpix [NC+1];
    logic signed [PW-1:0] lpos [NC+1];
    logic                 lvld [NC+1];
    logic [SW-1:0]        sl   [NC];
    logic [SW-1:0]        sr   [NC];

    assign lpix[0] = in_pix;
    assign lpos[0] = in_pos;
    assign lvld[0] = in_vld;

    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        sadwta_cell #(.PW(PW), .SW(SW), .DW(DW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .disp     (DW'(k)),
            .left_pix (left_pix),
            .left_pos (left_pos),
            .lo       (lo),
            .hi       (hi),
            .wlim     (wlim),
            .in_pix   (lpix[k]),
            .in_pos   (lpos[k]),
            .in_vld   (lvld[k]),
            .out_pix  (lpix[k+1]),
            .out_pos  (lpos[k+1]),
            .out_vld  (lvld[k+1]),
            .sum_l    (sl[k]),
            .sum_r    (sr[k])
        );
    end

    assign sel_sum_l = sl[sel];
    assign sel_sum_r = sr[sel];

endmodule

/* verif/stereo_sad_disparity_wta_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_sad_disparity_wta_core_tb
// Self-checking bench for the SAD winner-take-all stereo core. Whole frames
// of pixel pairs are streamed in, each at one register setting. Every word
// on the result channel is checked against a disparity predictor kept
// inside the bench. Both channels idle at random, and the result side holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module stereo_sad_disparity_wta_core_tb;
    import sadwta_pkg::*;

    localparam int LINES     = 15;
    localparam int LINE_LEN  = 1024;
    localparam int WDOG_MAX  = 20000;
    localparam int SETTLE    = 2000;

    typedef struct {
        logic [9:0] row;
        logic [9:0] col;
        logic [7:0] disp_l;
        logic [7:0] disp_r;
        logic       frame_end;
    } disp_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // predictor state
    logic [7:0] left_rows [LINES*LINE_LEN];
    logic [7:0] right_rows[LINES*LINE_LEN];
    int cur_row, cur_col;
    int radius, max_d, scale, img_w, img_h;

    disp_word_t pending_disp[$];
    int mismatches;
    int idle_cycles;
    int hold_off;       // long result-side stall requested by a test
    bit quiet_src, quiet_dst;

    stereo_sad_disparity_wta_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int absdiff(int a, int b);
        return a > b ? a - b : b - a;
    endfunction

    function automatic logic [7:0] scaled_disp(int d);
        int v;
        v = d * scale;
        return v > 254 ? DISP_CAP : v[7:0];
    endfunction

    function automatic disp_word_t match_centre(int i, int j);
        disp_word_t res;
        int bound, best_l, best_r, dl, dr, sl, sr, base;
        bit found_l, found_r;
        bound = 255 * (2*radius + 1) * (2*radius + 1);
        best_l = bound;
        best_r = bound;
        dl = 0;
        dr = 0;
        found_l = 0;
        found_r = 0;
        for (int d = 0; d <= max_d; d++)
        begin
            sl = 0;
            sr = 0;
            for (int y = i - radius; y <= i + radius; y++)
            begin
                base = (y % LINES) * LINE_LEN;
                for (int x = j - radius; x <= j + radius; x++)
                begin
                    // positions off the other image cost the disparity itself
                    if (x >= d)
                        sl += absdiff(left_rows[base+x], right_rows[base+x-d]);
                    else
                        sl += d;
                    if (x + d < img_w)
                        sr += absdiff(left_rows[base+x+d], right_rows[base+x]);
                    else
                        sr += d;
                end
            end
            if (sl < best_l)
            begin
                best_l = sl;
                dl = d;
                found_l = 1;
            end
            if (sr < best_r)
            begin
                best_r = sr;
                dr = d;
                found_r = 1;
            end
        end
        res.row = i[9:0];
        res.col = j[9:0];
        res.disp_l = found_l ? scaled_disp(dl) : 8'd0;
        res.disp_r = found_r ? scaled_disp(dr) : 8'd0;
        res.frame_end = (i == img_h - 1 - radius) && (j == img_w - 1 - radius);
        return res;
    endfunction

    task automatic predict_pixel(logic [7:0] lp, logic [7:0] rp);
        int span, i, last, next_j, j;
        span = 2*radius + 1;
        left_rows[(cur_row % LINES)*LINE_LEN + cur_col] = lp;
        right_rows[(cur_row % LINES)*LINE_LEN + cur_col] = rp;
        if (img_w >= span && img_h >= span && cur_row >= 2*radius && cur_row <= img_h - 1)
        begin
            i = cur_row - radius;
            last = img_w - 1 - radius;
            next_j = radius;
            if (cur_col >= radius + max_d)
            begin
                j = cur_col - radius - max_d;
                if (j >= radius && j <= last)
                    pending_disp.insert(pending_disp.size(), match_centre(i, j));
                if (j + 1 > next_j)
                    next_j = j + 1;
            end
            // end of row flushes every centre not yet emitted
            if (cur_col >= img_w - 1)
                for (j = next_j; j <= last; j++)
                    pending_disp.insert(pending_disp.size(), match_centre(i, j));
        end
        if (cur_col + 1 >= img_w)
        begin
            cur_col = 0;
            cur_row = (cur_row + 1 >= img_h) ? 0 : cur_row + 1;
        end
        else
        begin
            cur_col = cur_col + 1;
        end
    endtask

    task automatic reg_write(logic [2:0] idx, int value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_RADIUS: radius = value;
            REG_MAXD:   max_d = value;
            REG_SCALE:  scale = value;
            REG_WIDTH:  img_w = value;
            REG_HEIGHT: img_h = value;
            default: ;
        endcase
    endtask

    task automatic set_matcher(int r, int dm, int sc, int w, int h);
        reg_write(REG_RADIUS, r);
        reg_write(REG_MAXD, dm);
        reg_write(REG_SCALE, sc);
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
    endtask

    task automatic send_pixel(logic [7:0] lp, logic [7:0] rp);
        int gap;
        if ($urandom_range(0, 63) == 0)
            quiet_src = ~quiet_src;
        gap = quiet_src ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {rp, lp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_pixel(lp, rp);
    endtask

    // wait until every result is in and the core has gone quiet
    task automatic drain;
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_disp.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // pattern: 0 random, 1 shifted copy, 2 shifted copy with noise,
    // 3 black/white extremes, 4 flat gray, 5 one of these per row
    task automatic send_frame(int pattern);
        logic [7:0] lpix[];
        int sh, x2, v, pat;
        lpix = new[img_w * img_h];
        sh = $urandom_range(0, (max_d < img_w / 2) ? max_d : img_w / 2);
        foreach (lpix[k])
            lpix[k] = 8'($urandom_range(0, 255));
        for (int y = 0; y < img_h; y++)
        begin
            for (int x = 0; x < img_w; x++)
            begin
                pat = (pattern == 5) ? y % 5 : pattern;
                case (pat)
                    1, 2:
                    begin
                        x2 = x + sh;
                        v = x2 < img_w ? lpix[y*img_w + x2] : $urandom_range(0, 255);
                        if (pat == 2)
                            v = v + $urandom_range(0, 6) - 3;
                        v = v < 0 ? 0 : (v > 255 ? 255 : v);
                        send_pixel(lpix[y*img_w + x], v[7:0]);
                    end
                    3: send_pixel(((x + y) % 2) ? 8'd255 : 8'd0, (x % 3 == 0) ? 8'd255 : 8'd0);
                    4: send_pixel(8'd128, 8'd128);
                    default: send_pixel(lpix[y*img_w + x], 8'($urandom_range(0, 255)));
                endcase
            end
        end
        drain();
    endtask

    task automatic test_largest_window;
        set_matcher(7, 47, 255, 16, 16);
        send_frame(1);
    endtask

    task automatic test_mixed_rows_backpressure;
        set_matcher(1, 5, 60, 16, 16);
        hold_off = 3000;
        send_frame(5);
    endtask

    // result side
    initial
    begin
        int gap;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                quiet_dst = ~quiet_dst;
            if (hold_off > 0)
            begin
                gap = hold_off;
                hold_off = 0;
            end
            else
            begin
                gap = quiet_dst ? 0 : $urandom_range(0, 11);
            end
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        disp_word_t exp_w;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_disp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %h last %b", m_tdata, m_tlast);
            end
            else
            begin
                exp_w = pending_disp.pop_front();
                if (m_tdata[9:0] !== exp_w.row || m_tdata[19:10] !== exp_w.col
                    || m_tdata[27:20] !== exp_w.disp_l || m_tdata[35:28] !== exp_w.disp_r
                    || m_tlast !== exp_w.frame_end)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("exp %0d/%0d dl %0d dr %0d last %b got %0d/%0d dl %0d dr %0d last %b",
                                 exp_w.row, exp_w.col, exp_w.disp_l, exp_w.disp_r,
                                 exp_w.frame_end, m_tdata[9:0], m_tdata[19:10],
                                 m_tdata[27:20], m_tdata[35:28], m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles == WDOG_MAX)
            begin
                $display("[stereo_sad_disparity_wta_core] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        idle_cycles = 0;
        hold_off = 0;
        quiet_src = 0;
        quiet_dst = 0;
        cur_row = 0;
        cur_col = 0;
        radius = 2;
        max_d = 15;
        scale = 15;
        img_w = 640;
        img_h = 480;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_largest_window();
        test_mixed_rows_backpressure();

        if (mismatches == 0 && pending_disp.size() == 0)
            $display("[stereo_sad_disparity_wta_core] OK");
        else
            $display("[stereo_sad_disparity_wta_core] ERROR");
        $finish;
    end

endmodule
